[design/olte_pkg.sv]
`timescale 1ns / 1ps

package olte_pkg;

   typedef struct packed {
      logic        [2:0]  kind;
      logic        [7:0]  position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic        [1:0]  status;
      logic signed [31:0] value_out;
      logic        [7:0]  position_out;
      logic        [7:0]  length_out;
   } rsp_type;

   localparam logic [2:0] KIND_APPEND = 3'd0;
   localparam logic [2:0] KIND_INSERT = 3'd1;
   localparam logic [2:0] KIND_DELPOS = 3'd2;
   localparam logic [2:0] KIND_DELVAL = 3'd3;
   localparam logic [2:0] KIND_LOCATE = 3'd4;
   localparam logic [2:0] KIND_GET    = 3'd5;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_BADPOS   = 2'd2;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

   localparam logic [2:0] CELL_HOLD   = 3'd0;
   localparam logic [2:0] CELL_LOAD   = 3'd1;
   localparam logic [2:0] CELL_SHIFT  = 3'd2;
   localparam logic [2:0] CELL_INSERT = 3'd3;
   localparam logic [2:0] CELL_REMOVE = 3'd4;

   typedef struct packed {
      logic        [2:0]  op;
      logic signed [31:0] value;
   } cell_cmd_type;

endpackage

[design/olte_cell.sv]
`timescale 1ns / 1ps

module olte_cell #(
   parameter int DEPTH = 128,
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  olte_pkg::cell_cmd_type         cmd,
   input  logic [$clog2(DEPTH)-1:0]       target,
   input  logic signed [31:0]             left_value,
   input  logic signed [31:0]             right_value,
   input  logic signed [31:0]             right_scan,
   output logic signed [31:0]             value,
   output logic signed [31:0]             scan
);
   import olte_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic signed [31:0] scan_ff;
   logic signed [31:0] scan_in;

   always_comb begin
      value_in = value_ff;
      scan_in  = scan_ff;
      unique case (cmd.op)
         CELL_LOAD: begin
            scan_in = value_ff;
         end
         CELL_SHIFT: begin
            scan_in = right_scan;
         end
         CELL_INSERT: begin
            if (MY_INDEX == target) begin
               value_in = cmd.value;
            end else if (MY_INDEX > target) begin
               value_in = left_value;
            end
         end
         CELL_REMOVE: begin
            if (MY_INDEX >= target) begin
               value_in = right_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      scan_ff  <= scan_in;
   end

   assign value = value_ff;
   assign scan  = scan_ff;

endmodule

[design/olte_ctrl.sv]
`timescale 1ns / 1ps

module olte_ctrl #(
   parameter int DEPTH = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  olte_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output olte_pkg::rsp_type          rsp_data,
   output olte_pkg::cell_cmd_type     cell_cmd,
   output logic [$clog2(DEPTH)-1:0]   cell_target,
   input  logic signed [31:0]         scan_head
);
   import olte_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic               state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [2:0]         kind_ff, kind_in;
   logic [7:0]         pos_ff, pos_in;
   logic signed [31:0] key_ff, key_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               take;
   logic               full;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   cnt_ext;
   logic               hit;
   logic               done;

   assign req_stall = (state_ff != ST_IDLE) | (rsp_valid_ff & rsp_stall);
   assign take      = req_valid & ~req_stall;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pos_ext   = CMP_W'(req_data.position);
   assign cnt_ext   = CMP_W'(count_ff);

   always_comb begin
      if ((kind_ff == KIND_DELPOS) || (kind_ff == KIND_GET)) begin
         hit = (CMP_W'(k_ff) == (CMP_W'(pos_ff) - CMP_W'(1)));
      end else begin
         hit = (scan_head == key_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cell_cmd.op    = CELL_HOLD;
      cell_cmd.value = req_data.value;
      cell_target    = '0;
      done           = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               rsp_in.status       = STATUS_OK;
               rsp_in.value_out    = '0;
               rsp_in.position_out = '0;
               done                = 1'b1;
               unique case (req_data.kind) inside
                  KIND_APPEND: begin
                     if (full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        cell_cmd.op = CELL_INSERT;
                        cell_target = count_ff[IDX_W-1:0];
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_INSERT: begin
                     if (full) begin
                        rsp_in.status = STATUS_FULL;
                     end else if ((pos_ext == '0) || (pos_ext > (cnt_ext + CMP_W'(1)))) begin
                        rsp_in.status = STATUS_BADPOS;
                     end else begin
                        cell_cmd.op = CELL_INSERT;
                        cell_target = IDX_W'(pos_ext - CMP_W'(1));
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  KIND_DELPOS, KIND_GET: begin
                     if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
                        rsp_in.status = STATUS_BADPOS;
                     end else begin
                        cell_cmd.op = CELL_LOAD;
                        done        = 1'b0;
                        state_in    = ST_SCAN;
                        k_in        = '0;
                        kind_in     = req_data.kind;
                        pos_in      = req_data.position;
                     end
                  end
                  KIND_DELVAL, KIND_LOCATE: begin
                     cell_cmd.op = CELL_LOAD;
                     done        = 1'b0;
                     state_in    = ST_SCAN;
                     k_in        = '0;
                     kind_in     = req_data.kind;
                     key_in      = req_data.value;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (k_ff >= count_ff) begin
               rsp_in.status       = STATUS_NOTFOUND;
               rsp_in.value_out    = '0;
               rsp_in.position_out = '0;
               done                = 1'b1;
               state_in            = ST_IDLE;
            end else if (hit) begin
               rsp_in.status       = STATUS_OK;
               rsp_in.value_out    = scan_head;
               rsp_in.position_out = 8'(k_ff + CNT_W'(1));
               done                = 1'b1;
               state_in            = ST_IDLE;
               if ((kind_ff == KIND_DELPOS) || (kind_ff == KIND_DELVAL)) begin
                  cell_cmd.op = CELL_REMOVE;
                  cell_target = k_ff[IDX_W-1:0];
                  count_in    = count_ff - CNT_W'(1);
               end
            end else begin
               cell_cmd.op = CELL_SHIFT;
               k_in        = k_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         rsp_in.length_out = 8'(count_in);
         rsp_valid_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff    <= k_in;
      kind_ff <= kind_in;
      pos_ff  <= pos_in;
      key_ff  <= key_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (k_ff <= count_ff))
      else $error("scan index past list length");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((count_ff == $past(count_ff))
                         || (count_ff == CNT_W'($past(count_ff) + CNT_W'(1)))
                         || (count_ff == CNT_W'($past(count_ff) - CNT_W'(1)))))
      else $error("entry count moved by more than one");

   a_count_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> rsp_valid_ff)
      else $error("list changed without a result beat");
`endif

endmodule

[design/ordered_list_table_engine.sv]
`timescale 1ns / 1ps
// Append, insert, failed and unused requests give a registered result beat straight from idle.
// Get and delete at position p scan the list from the head up to position p; locate and
// delete by value scan up to the first match, or past the last entry when there is no match.
// One request is handled at a time; the next request is taken once the result beat is
// registered and not stalled.
// Reset clears the length and the control state; entry contents are not cleared.
module ordered_list_table_engine #(
   parameter int DEPTH = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  olte_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output olte_pkg::rsp_type   rsp_data
);
   import olte_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);

   cell_cmd_type       cell_cmd;
   logic [IDX_W-1:0]   cell_target;
   logic signed [31:0] value_w [DEPTH];
   logic signed [31:0] scan_w  [DEPTH];

   olte_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .cell_cmd    (cell_cmd),
      .cell_target (cell_target),
      .scan_head   (scan_w[0])
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int LEFT  = (i == 0) ? 0 : i - 1;
      localparam int RIGHT = (i == DEPTH - 1) ? i : i + 1;

      olte_cell #(
         .DEPTH(DEPTH),
         .INDEX(i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .target      (cell_target),
         .left_value  (value_w[LEFT]),
         .right_value (value_w[RIGHT]),
         .right_scan  (scan_w[RIGHT]),
         .value       (value_w[i]),
         .scan        (scan_w[i])
      );
   end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import olte_pkg::*;

   localparam int LIST_DEPTH  = 128;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 150;

   typedef struct packed {
      bit      drain;
      req_type req;
   } pending_beat_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pending_beat_type   queued_requests[$];
   rsp_type            awaited_rsp[$];
   logic signed [31:0] shadow_list[LIST_DEPTH];
   int                 shadow_len  = 0;
   int                 peak_len    = 0;
   int                 status_seen[4];
   int                 mismatches  = 0;
   int                 cycles      = 0;
   bit                 steady      = 1'b0;
   rsp_type            want;

   ordered_list_table_engine #(
      .DEPTH(LIST_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic void drop_entry(input int slot);
      for (int i = slot; i + 1 < shadow_len; i++) begin
         shadow_list[i] = shadow_list[i + 1];
      end
      shadow_len--;
   endfunction

   function automatic rsp_type list_outcome(input req_type r);
      rsp_type o;
      int      slot;
      o = '0;
      o.status = STATUS_OK;
      case (r.kind) inside
         KIND_APPEND: begin
            if (shadow_len >= LIST_DEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               shadow_list[shadow_len] = r.value;
               shadow_len++;
            end
         end
         KIND_INSERT: begin
            if (shadow_len >= LIST_DEPTH) begin
               o.status = STATUS_FULL;
            end else if (r.position == 0 || int'(r.position) > shadow_len + 1) begin
               o.status = STATUS_BADPOS;
            end else begin
               for (int i = shadow_len; i >= int'(r.position); i--) begin
                  shadow_list[i] = shadow_list[i - 1];
               end
               shadow_list[r.position - 1] = r.value;
               shadow_len++;
            end
         end
         KIND_DELPOS, KIND_GET: begin
            if (r.position == 0 || int'(r.position) > shadow_len) begin
               o.status = STATUS_BADPOS;
            end else begin
               o.value_out    = shadow_list[r.position - 1];
               o.position_out = r.position;
               if (r.kind == KIND_DELPOS) begin
                  drop_entry(r.position - 1);
               end
            end
         end
         KIND_DELVAL, KIND_LOCATE: begin
            slot = -1;
            for (int i = 0; i < shadow_len; i++) begin
               if (slot < 0 && shadow_list[i] == r.value) begin
                  slot = i;
               end
            end
            if (slot < 0) begin
               o.status = STATUS_NOTFOUND;
            end else begin
               o.value_out    = shadow_list[slot];
               o.position_out = 8'(slot + 1);
               if (r.kind == KIND_DELVAL) begin
                  drop_entry(slot);
               end
            end
         end
         default: ;
      endcase
      if (shadow_len > peak_len) begin
         peak_len = shadow_len;
      end
      o.length_out = 8'(shadow_len);
      return o;
   endfunction

   task automatic note_failure(input string msg);
      if (mismatches < 10) begin
         $display("ERROR at cycle %0d: %s", cycles, msg);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_rsp.push_back(list_outcome(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (queued_requests.size() != 0
                && !(queued_requests[0].drain && awaited_rsp.size() != 0)
                && (steady || $urandom_range(0, 99) >= 37)) begin
               req_valid <= 1'b1;
               req_data  <= queued_requests[0].req;
               queued_requests.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               note_failure($sformatf("result beat with none expected: %p", rsp_data));
            end else begin
               want = awaited_rsp.pop_front();
               status_seen[want.status]++;
               if (rsp_data.status !== want.status
                   || rsp_data.value_out !== want.value_out
                   || rsp_data.position_out !== want.position_out
                   || rsp_data.length_out !== want.length_out) begin
                  note_failure($sformatf(
                     "status %0d/%0d value %0d/%0d position %0d/%0d length %0d/%0d (exp/act)",
                     want.status, rsp_data.status, want.value_out, rsp_data.value_out,
                     want.position_out, rsp_data.position_out,
                     want.length_out, rsp_data.length_out));
               end
            end
         end
         rsp_stall <= !steady && ($urandom_range(0, 99) < 37);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycles, awaited_rsp.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic queue_directed(input logic [2:0] kind, input int pos, input int val);
      pending_beat_type b;
      b.drain        = 1'b0;
      b.req.kind     = kind;
      b.req.position = 8'(pos);
      b.req.value    = val;
      queued_requests.push_back(b);
   endtask

   // grow: percent of beats that append or insert
   task automatic queue_random(input int count, input int grow);
      pending_beat_type b;
      int               pick;
      for (int n = 0; n < count; n++) begin
         while (queued_requests.size() >= 2) @(posedge clock);
         b.drain = (n == 0);
         pick = $urandom_range(0, 99);
         if (pick < grow) begin
            b.req.kind = $urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT;
         end else if (pick < 95) begin
            b.req.kind = 3'(KIND_DELPOS + $urandom_range(0, 3));
         end else begin
            b.req.kind = 3'($urandom_range(0, 7));
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            b.req.position = 8'($urandom_range(1, shadow_len + 1));
         end else if (pick < 80) begin
            b.req.position = 0;
         end else if (pick < 90) begin
            b.req.position = 8'(shadow_len + $urandom_range(0, 2));
         end else begin
            b.req.position = 8'($urandom_range(0, 255));
         end
         pick = $urandom_range(0, 99);
         if (pick < 45 && shadow_len > 0) begin
            b.req.value = shadow_list[$urandom_range(0, shadow_len - 1)];
         end else if (pick < 70) begin
            b.req.value = int'($urandom_range(0, 8)) - 4;
         end else if (pick < 75) begin
            b.req.value = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         end else begin
            b.req.value = $urandom;
         end
         queued_requests.push_back(b);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty list corners, then a short list with duplicates
      queue_directed(KIND_GET,    1,   9);
      queue_directed(KIND_DELPOS, 0,   9);
      queue_directed(KIND_DELVAL, 3,   5);
      queue_directed(KIND_LOCATE, 1,   0);
      queue_directed(KIND_INSERT, 0,   1);
      queue_directed(KIND_INSERT, 2,   1);
      queue_directed(KIND_INSERT, 1,   32'h7fffffff);
      queue_directed(KIND_APPEND, 200, 32'h80000000);
      queue_directed(KIND_APPEND, 0,   -1);
      queue_directed(KIND_INSERT, 4,   0);
      queue_directed(KIND_INSERT, 2,   7);
      queue_directed(KIND_APPEND, 255, 7);
      queue_directed(KIND_LOCATE, 0,   7);
      queue_directed(KIND_GET,    6,   0);
      queue_directed(KIND_GET,    7,   0);
      queue_directed(KIND_GET,    255, -1);
      queue_directed(3'd6,        255, -1);
      queue_directed(3'd7,        1,   32'h7fffffff);
      queue_directed(KIND_DELVAL, 1,   7);
      queue_directed(KIND_LOCATE, 2,   7);
      queue_directed(KIND_DELPOS, 5,   3);
      queue_directed(KIND_DELPOS, 1,   3);
      queue_directed(KIND_DELVAL, 0,   12345);
      queue_directed(KIND_DELPOS, 4,   0);
      queue_directed(KIND_LOCATE, 0,   32'h80000000);

      queue_random(150, 90);
      steady = 1'b1;
      queue_random(120, 45);
      steady = 1'b0;
      queue_random(200, 10);
      queue_random(360, 50);

      while (queued_requests.size() != 0 || req_valid || awaited_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);

      $display("Checked %0d results: %0d ok, %0d full, %0d bad position, %0d not found",
               status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
               status_seen[STATUS_OK], status_seen[STATUS_FULL],
               status_seen[STATUS_BADPOS], status_seen[STATUS_NOTFOUND]);
      $display("Longest list reached %0d of %0d entries, %0d mismatches",
               peak_len, LIST_DEPTH, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
